// ===== design/dnkf_pkg.sv =====
// ----------------------------------------------------------------------------
// dnkf_pkg
// Shared types and constants for the distinct nibble key filler.
// ----------------------------------------------------------------------------
`default_nettype none

package dnkf_pkg;

  localparam logic [63:0] WEYL_INC_RESET = 64'hb5ad4eceda1ce2a9;
  localparam int unsigned DIGIT_COUNT    = 7;
  localparam int unsigned MAX_DRAWS      = 256;
  localparam int unsigned CNT_W          = $clog2(DIGIT_COUNT + 1);
  localparam int unsigned DRAW_W         = $clog2(MAX_DRAWS + 1);

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic scan;
    logic emit;
  } dnkf_cmd_t;

  typedef struct packed {
    logic finished;
    logic out_busy;
  } dnkf_status_t;

endpackage

`default_nettype wire

// ===== design/dnkf_if.sv =====
// ----------------------------------------------------------------------------
// dnkf_if
// Valid/ready channels for key requests and completed keys.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnkf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] lower_digits;
  logic [3:0]  round_number;

  modport source (output valid, output lower_digits, output round_number, input ready);
  modport sink   (input valid, input lower_digits, input round_number, output ready);
endinterface

interface dnkf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word;
  logic        input_error;

  modport source (output valid, output key_word, output input_error, input ready);
  modport sink   (input valid, input key_word, input input_error, output ready);
endinterface

`default_nettype wire

// ===== design/dnkf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dnkf_ctrl
// Sequencer: one draw is multiply low, multiply cross, add, scan, test.
// ----------------------------------------------------------------------------
`default_nettype none

module dnkf_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  dnkf_pkg::dnkf_status_t status,
  output dnkf_pkg::dnkf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_SCAN,
    ST_TEST,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        state_nxt = status.finished ? ST_DONE : ST_MUL_LO;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dnkf_datapath.sv =====
// ----------------------------------------------------------------------------
// dnkf_datapath
// Middle-square Weyl generator, nibble scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnkf_datapath (
  input  wire                   clk,
  input  wire                   rst_n,
  input  dnkf_pkg::dnkf_cmd_t    cmd,
  output dnkf_pkg::dnkf_status_t status,
  input  wire                   cfg_we,
  input  wire  [63:0]           cfg_wdata,
  input  wire  [31:0]           in_lower_digits,
  input  wire  [3:0]            in_round_number,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [63:0]           out_key_word,
  output logic                  out_input_error
);

  localparam int unsigned CW = dnkf_pkg::CNT_W;
  localparam int unsigned DW = dnkf_pkg::DRAW_W;

  logic [63:0]   inc_r;
  logic [63:0]   sq_r;
  logic [63:0]   ws_r;
  logic [63:0]   p0_r;
  logic [31:0]   p1_r;
  logic [31:0]   word_r;
  logic [DW-1:0] draws_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   used_r, used_nxt;
  logic [27:0]   upper_r, upper_nxt;
  logic [31:0]   low_r;
  logic [3:0]    ninth_r;
  logic          out_valid_r;
  logic [63:0]   key_r;
  logic          err_r;

  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [63:0] sum_v;
  logic [3:0]  top;
  logic [4:0]  ninth_s;
  logic [3:0]  ninth_m;

  assign mul_a = cmd.mul_hi ? sq_r[63:32] : sq_r[31:0];
  assign prod  = 64'(mul_a) * 64'(sq_r[31:0]);
  // low 64 bits of the square plus the Weyl value: lo*lo + 2*hi*lo*2^32 + ws
  assign sum_v = p0_r + {p1_r[30:0], 33'd0} + ws_r;

  assign top     = in_lower_digits[31:28];
  assign ninth_s = 5'(top) + 5'(in_round_number);
  always_comb begin
    if (ninth_s >= 5'd30) begin
      ninth_m = 4'd0;
    end else if (ninth_s >= 5'd15) begin
      ninth_m = 4'(ninth_s - 5'd15);
    end else begin
      ninth_m = ninth_s[3:0];
    end
  end

  always_comb begin
    logic [3:0] d;
    used_nxt  = used_r;
    cnt_nxt   = cnt_r;
    upper_nxt = upper_r;
    for (int i = 0; i < 8; i++) begin
      d = word_r[4*i +: 4];
      if (cnt_nxt != CW'(dnkf_pkg::DIGIT_COUNT) && d != 4'd0 && !used_nxt[d]) begin
        used_nxt[d] = 1'b1;
        upper_nxt[{3'(CW'(dnkf_pkg::DIGIT_COUNT - 1) - cnt_nxt), 2'b00} +: 4] = d;
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end
  end

  assign status.finished = (cnt_r == CW'(dnkf_pkg::DIGIT_COUNT)) ||
                           (draws_r == DW'(dnkf_pkg::MAX_DRAWS));
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r       <= dnkf_pkg::WEYL_INC_RESET;
      sq_r        <= '0;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        inc_r <= cfg_wdata;
      end
      if (cmd.mul_lo) begin
        ws_r <= ws_r + inc_r;
      end
      if (cmd.add) begin
        sq_r <= {sum_v[31:0], sum_v[63:32]};
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low_r   <= in_lower_digits;
      ninth_r <= ninth_m + 4'd1;
      used_r  <= 16'(1) << top;
      cnt_r   <= '0;
      upper_r <= '0;
      draws_r <= '0;
    end
    if (cmd.mul_lo) begin
      p0_r <= prod;
    end
    if (cmd.mul_hi) begin
      p1_r <= prod[31:0];
    end
    if (cmd.add) begin
      word_r  <= sum_v[63:32];
      draws_r <= draws_r + 1'b1;
    end
    if (cmd.scan) begin
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      upper_r <= upper_nxt;
    end
    if (cmd.emit) begin
      key_r <= {upper_r, ninth_r, low_r};
      err_r <= (low_r[31:28] == 4'd0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_word    = key_r;
  assign out_input_error = err_r;

endmodule

`default_nettype wire

// ===== design/distinct_nibble_key_filler_core.sv =====
// ----------------------------------------------------------------------------
// distinct_nibble_key_filler_core
// Completes a 64-bit key from its low eight nibbles and a round number.
//
// in_ch carries lower_digits and round_number; a transfer starts one key.
// out_ch returns key_word and input_error, one per request, in order.
// cfg_we/cfg_wdata write the Weyl increment; write only while idle.
// Each generator draw makes two passes through the shared 32x32
// multiplier, then a 64-bit add, a nibble scan and a completion test.
// A key needs at most 256 draws; one key is in flight at a time, so
// a new request is taken only once the last key has left the datapath.
// The result sits in an output register, so a new request is taken
// while an earlier key waits; if the receiver stalls, the next finished
// key waits in the datapath until the output register frees up.
// Reset clears the generator state and restores the default increment.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_nibble_key_filler_core (
  input  wire         clk,
  input  wire         rst_n,
  dnkf_in_if.sink     in_ch,
  dnkf_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire  [63:0] cfg_wdata
);

  dnkf_pkg::dnkf_cmd_t    cmd;
  dnkf_pkg::dnkf_status_t status;

  dnkf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dnkf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_lower_digits (in_ch.lower_digits),
    .in_round_number (in_ch.round_number),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_key_word    (out_ch.key_word),
    .out_input_error (out_ch.input_error)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a key is in progress");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_lo, cmd.mul_hi, cmd.add, cmd.scan, cmd.emit}))
    else $error("more than one datapath command");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted key not presented");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for distinct_nibble_key_filler_core. A driver feeds key
// requests from a queue and predicts each completed key at its transfer; a
// monitor checks every returned key against the oldest prediction. Runs
// several Weyl increments: zero (starved generator), default, extremes and
// random values, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned KEY_LATENCY = 5 * dnkf_pkg::MAX_DRAWS + 2;
  localparam int unsigned CYCLE_LIMIT = 1500 * (KEY_LATENCY + 2 * MAX_GAP) * 3;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_KEYS  = 225;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct packed {
    logic [31:0] lower_digits;
    logic [3:0]  round_number;
  } key_request_t;

  typedef struct packed {
    logic [63:0] key_word;
    logic        input_error;
  } key_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  dnkf_in_if  key_req_if ();
  dnkf_out_if key_out_if ();

  distinct_nibble_key_filler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (key_req_if),
    .out_ch    (key_out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // generator copy
  logic [63:0] gen_increment;
  logic [63:0] gen_square;
  logic [63:0] gen_weyl;

  key_request_t request_fifo[$];
  key_result_t  expected_keys[$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned keys_checked;
  int unsigned flagged_keys;
  int unsigned starved_keys;
  int unsigned settings_used;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic key_result_t complete_key(key_request_t req);
    key_result_t res;
    logic [63:0] v;
    logic [31:0] word;
    logic [15:0] used;
    logic [3:0]  top;
    logic [3:0]  ninth;
    logic [3:0]  d;
    int unsigned pos;
    int unsigned draws;
    int unsigned sh;
    top   = req.lower_digits[31:28];
    ninth = 4'(((int'(top) + int'(req.round_number)) % 15) + 1);
    res.key_word = {28'h0, ninth, req.lower_digits};
    used  = 16'h1 << top;
    pos   = 60;
    draws = 0;
    while (pos > 32 && draws < dnkf_pkg::MAX_DRAWS) begin
      v = gen_square * gen_square;
      gen_weyl = gen_weyl + gen_increment;
      v = v + gen_weyl;
      v = {v[31:0], v[63:32]};
      gen_square = v;
      word = v[31:0];
      draws++;
      for (sh = 0; sh < 32 && pos > 32; sh += 4) begin
        d = word[sh +: 4];
        if (d != 4'h0 && !used[d]) begin
          used[d] = 1'b1;
          res.key_word[pos +: 4] = d;
          pos -= 4;
        end
      end
    end
    if (pos > 32) starved_keys++;
    res.input_error = (top == 4'h0);
    return res;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic key_request_t random_request();
    key_request_t r;
    logic [3:0] digits[15];
    logic [3:0] t;
    int j;
    int k;
    int kind;
    kind = $urandom_range(0, 99);
    for (j = 0; j < 15; j++) digits[j] = 4'(j + 1);
    for (j = 14; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = digits[j];
      digits[j] = digits[k];
      digits[k] = t;
    end
    for (j = 0; j < 8; j++) r.lower_digits[4*j +: 4] = digits[j];
    r.round_number = 4'($urandom_range(0, 13));
    if (kind >= 90) begin
      r.lower_digits = $urandom;
      r.round_number = 4'($urandom_range(0, 15));
    end else if (kind >= 82) begin
      j = $urandom_range(0, 7);
      k = $urandom_range(0, 7);
      r.lower_digits[4*j +: 4] = r.lower_digits[4*k +: 4];
    end else if (kind >= 76) begin
      r.lower_digits[31:28] = 4'h0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  task automatic push_key(input logic [31:0] lower, input logic [3:0] rnd);
    key_request_t r;
    r.lower_digits = lower;
    r.round_number = rnd;
    request_fifo.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_fifo.size() != 0 || key_req_if.valid || expected_keys.size() != 0);
  endtask

  task automatic write_increment(input logic [63:0] value);
    gen_increment = value;
    settings_used++;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // request driver
  bit          req_calm;
  int unsigned req_gap;

  always @(posedge clk) begin : drive_requests
    key_request_t cur;
    logic nxt_valid;
    if (!rst_n) begin
      key_req_if.valid <= 1'b0;
      req_gap  = 0;
      req_calm = 1'b0;
    end else begin
      nxt_valid = key_req_if.valid;
      if (key_req_if.valid && key_req_if.ready) begin
        cur.lower_digits = key_req_if.lower_digits;
        cur.round_number = key_req_if.round_number;
        expected_keys.push_back(complete_key(cur));
        if ($urandom_range(0, 63) == 0) req_calm = ~req_calm;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_fifo.size() > 0) begin
          cur = request_fifo.pop_front();
          key_req_if.lower_digits <= cur.lower_digits;
          key_req_if.round_number <= cur.round_number;
          nxt_valid = 1'b1;
          req_gap = pick_gap(req_calm);
        end
      end
      key_req_if.valid <= nxt_valid;
    end
  end

  // result monitor
  bit          out_calm;
  int unsigned out_stall;

  always @(posedge clk) begin : check_results
    key_result_t want;
    logic nxt_ready;
    if (!rst_n) begin
      key_out_if.ready <= 1'b0;
      out_stall = 0;
      out_calm  = 1'b0;
    end else begin
      if (key_out_if.valid && key_out_if.ready) begin
        if (expected_keys.size() == 0) begin
          note_mismatch($sformatf("key %h with no request outstanding", key_out_if.key_word));
        end else begin
          want = expected_keys.pop_front();
          keys_checked++;
          if (want.input_error) flagged_keys++;
          if (key_out_if.key_word !== want.key_word)
            note_mismatch($sformatf("key_word %h, expected %h",
                                    key_out_if.key_word, want.key_word));
          if (key_out_if.input_error !== want.input_error)
            note_mismatch($sformatf("input_error %b, expected %b (key %h)",
                                    key_out_if.input_error, want.input_error,
                                    want.key_word));
        end
        if ($urandom_range(0, 63) == 0) out_calm = ~out_calm;
      end
      if (out_stall > 0) begin
        out_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if ($urandom_range(0, 7) == 0) out_stall = pick_gap(out_calm);
      end
      key_out_if.ready <= nxt_ready;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned i;
    logic [63:0] inc;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = 64'h0;
    key_req_if.valid        = 1'b0;
    key_req_if.lower_digits = 32'h0;
    key_req_if.round_number = 4'h0;
    key_out_if.ready        = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    keys_checked  = 0;
    flagged_keys  = 0;
    starved_keys  = 0;
    settings_used = 0;
    gen_increment = dnkf_pkg::WEYL_INC_RESET;
    gen_square    = 64'h0;
    gen_weyl      = 64'h0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero increment from reset state: generator never yields a digit
    write_increment(64'h0);
    push_key(32'h12345678, 4'd3);
    push_key(32'h0abcdef1, 4'd15);
    push_key(32'hffffffff, 4'd0);
    wait_drained();

    write_increment(dnkf_pkg::WEYL_INC_RESET);
    push_key(32'h12345678, 4'd0);
    push_key(32'h87654321, 4'd13);
    push_key(32'hf1234567, 4'd13);
    push_key(32'hf1234567, 4'd0);
    push_key(32'h01234567, 4'd5);
    push_key(32'h00000000, 4'd0);
    push_key(32'hffffffff, 4'd15);
    push_key(32'hfedcba98, 4'd14);
    push_key(32'h9abcdef1, 4'd15);
    push_key(32'h0fedcba9, 4'd15);
    push_key(32'he0000000, 4'd1);
    push_key(32'h2468ace1, 4'd7);
    push_key(32'h13579bdf, 4'd12);
    push_key(32'h11111111, 4'd6);
    push_key(32'h5a5a5a5a, 4'd9);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       inc = 64'hffff_ffff_ffff_ffff;
        1:       inc = 64'h1;
        2:       inc = {$urandom, $urandom} | 64'h1;
        3:       inc = {$urandom, $urandom} & ~64'h1;
        4:       inc = 64'h8000_0000_0000_0001;
        default: inc = dnkf_pkg::WEYL_INC_RESET;
      endcase
      write_increment(inc);
      for (i = 0; i < PHASE_KEYS; i++) begin
        // sender holds off until every outstanding key is back
        if (p == 2 && i == PHASE_KEYS / 2) wait_drained();
        request_fifo.push_back(random_request());
      end
      wait_drained();
    end

    repeat (KEY_LATENCY) @(posedge clk);
    $display("checked %0d keys under %0d increment settings", keys_checked, settings_used);
    $display("%0d with zero top nibble, %0d with a starved generator",
             flagged_keys, starved_keys);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
